/* design/salc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and codes of the set-associative LRU cache tag store.
// ----------------------------------------------------------------------------
package salc_pkg;

    // Access kinds on the input tuser field.
    localparam logic [1:0] FUNC_MODIFY = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SET_BITS = 2'd0;
    localparam logic [1:0] CFG_OFFSET   = 2'd1;
    localparam logic [1:0] CFG_WAYS     = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int FUNC_W      = 2;
    localparam int ADDR_W      = 64;
    localparam int TOTAL_W     = 32;
    localparam int OUT_DATA_W  = 104;
    // Wide enough to hold a way count up to the largest supported way number.
    localparam int WAYS_CNT_W  = 5;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } ctrl_state_t;

    typedef struct packed {
        logic clear_we;
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

/* design/salc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_ctrl
// Controller: sequences the clearing pass, item accept, evaluation and the
// output register handshake.
// ----------------------------------------------------------------------------
module salc_ctrl import salc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd.clear_we = (state_reg == ST_CLEAR);
        cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.commit   = (state_reg == ST_EVAL) && out_free;
        s_tready     = (state_reg == ST_IDLE);
        m_tvalid     = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // An accepted beat is always evaluated in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EVAL))
        else $error("accepted beat not followed by evaluation");

    // A new result only appears after a commit, which also writes the set back for an access.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result raised without a commit");

    // Evaluation waits while the output register is still occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && !cmd.commit) |=> (state_reg == ST_EVAL))
        else $error("evaluation left without a commit");

    // No input is taken during the clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!cmd.accept && !cmd.commit))
        else $error("item activity during clearing pass");

endmodule

/* design/salc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_datapath
// Datapath: configuration registers, address decode, set memories, way
// compare, LRU update and saturating totals.
// ----------------------------------------------------------------------------
module salc_datapath import salc_pkg::*; #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [FUNC_W-1:0]      in_func,
    input  logic [ADDR_W-1:0]      in_address,
    output logic [OUT_DATA_W-1:0]  out_data
);

    localparam int SW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int RW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    // Largest set field width whose set count still fits the store.
    localparam int SMAX = $clog2(MAX_SETS + 1) - 1;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] v,
                                                   input logic [1:0] n);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, v} + (TOTAL_W + 1)'(n);
        return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    endfunction

    // Configuration.
    logic [2:0] set_bits_reg;
    logic [5:0] offset_reg;
    logic [3:0] ways_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg <= 3'd0;
            offset_reg   <= 6'd0;
            ways_reg     <= 4'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SET_BITS: set_bits_reg <= cfg_data[2:0];
                CFG_OFFSET:   offset_reg   <= cfg_data[5:0];
                CFG_WAYS:     ways_reg     <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Address decode for the incoming beat.
    logic [2:0]        s_eff;
    logic [SW-1:0]     set_mask;
    logic [ADDR_W-1:0] addr_sh;
    logic [SW-1:0]     rd_set;
    logic [6:0]        tag_shift;
    logic [ADDR_W-1:0] in_tag;

    always_comb begin
        s_eff     = (4'(set_bits_reg) > 4'(SMAX)) ? 3'(SMAX) : set_bits_reg;
        set_mask  = ~({SW{1'b1}} << s_eff);
        addr_sh   = in_address >> offset_reg;
        rd_set    = addr_sh[SW-1:0] & set_mask;
        tag_shift = 7'(offset_reg) + 7'(s_eff);
        // A shift of 64 or more leaves no tag bits.
        in_tag    = tag_shift[6] ? '0 : (in_address >> tag_shift[5:0]);
    end

    // Set memories and clearing pass.
    logic [MAX_WAYS-1:0]              valid_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][RW-1:0]      rank_mem  [MAX_SETS];
    logic [MAX_WAYS-1:0][ADDR_W-1:0]  tag_mem   [MAX_SETS];

    logic [MAX_WAYS-1:0]              vld_rd_reg;
    logic [MAX_WAYS-1:0][RW-1:0]      rank_rd_reg;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]  tag_rd_reg;
    logic [SW-1:0]                    set_reg;
    logic [ADDR_W-1:0]                tag_reg;
    logic [FUNC_W-1:0]                func_reg;
    logic [SW-1:0]                    clr_cnt_reg;
    logic [MAX_WAYS-1:0][RW-1:0]      rank_init;

    always_comb begin
        for (int k = 0; k < MAX_WAYS; k++) begin
            rank_init[k] = RW'(k);
        end
    end

    assign status.clear_last = (clr_cnt_reg == SW'(MAX_SETS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_we) begin
            clr_cnt_reg <= clr_cnt_reg + SW'(1);
        end
    end

    // Way compare and replacement choice.
    logic [WAYS_CNT_W-1:0] ways_eff;
    logic [MAX_WAYS-1:0]   inuse;
    logic [MAX_WAYS-1:0]   hit_vec;
    logic [MAX_WAYS-1:0]   hit_sel;
    logic [MAX_WAYS-1:0]   free_vec;
    logic [MAX_WAYS-1:0]   cand;
    logic [MAX_WAYS-1:0]   vict_sel;
    logic [MAX_WAYS-1:0]   sel;
    logic [RW-1:0]         sel_rank;
    logic                  hit_any;
    logic                  access;
    logic                  miss;
    logic                  evict;
    logic                  modify;
    logic [1:0]            hits_add;
    logic [MAX_WAYS-1:0]              vld_wr;
    logic [MAX_WAYS-1:0][RW-1:0]      rank_wr;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]  tag_wr;

    always_comb begin
        if (ways_reg == 4'd0) begin
            ways_eff = WAYS_CNT_W'(1);
        end else if (WAYS_CNT_W'(ways_reg) > WAYS_CNT_W'(MAX_WAYS)) begin
            ways_eff = WAYS_CNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WAYS_CNT_W'(ways_reg);
        end
        for (int k = 0; k < MAX_WAYS; k++) begin
            inuse[k]   = WAYS_CNT_W'(k) < ways_eff;
            hit_vec[k] = inuse[k] && vld_rd_reg[k] && (tag_rd_reg[k] == tag_reg);
        end
        hit_any  = |hit_vec;
        // Lowest matching way wins.
        hit_sel  = hit_vec & (~hit_vec + MAX_WAYS'(1));
        free_vec = inuse & ~vld_rd_reg;
        cand     = (|free_vec) ? free_vec : inuse;
        // Ranks within a set are distinct, so exactly one candidate is lowest.
        for (int k = 0; k < MAX_WAYS; k++) begin
            vict_sel[k] = cand[k];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (cand[j] && (rank_rd_reg[j] < rank_rd_reg[k])) vict_sel[k] = 1'b0;
            end
        end
        sel      = hit_any ? hit_sel : vict_sel;
        sel_rank = '0;
        for (int k = 0; k < MAX_WAYS; k++) begin
            sel_rank = sel_rank | ({RW{sel[k]}} & rank_rd_reg[k]);
        end
        for (int k = 0; k < MAX_WAYS; k++) begin
            if (sel[k]) begin
                rank_wr[k] = RW'(MAX_WAYS - 1);
            end else if (rank_rd_reg[k] > sel_rank) begin
                rank_wr[k] = rank_rd_reg[k] - RW'(1);
            end else begin
                rank_wr[k] = rank_rd_reg[k];
            end
            tag_wr[k] = (sel[k] && !hit_any) ? tag_reg : tag_rd_reg[k];
        end
        vld_wr   = vld_rd_reg | sel;
        access   = (func_reg != FUNC_NONE);
        modify   = (func_reg == FUNC_MODIFY);
        miss     = access && !hit_any;
        evict    = miss && !(|free_vec);
        // The second access of a modify always hits the line just touched.
        hits_add = {1'b0, access && hit_any} + {1'b0, modify};
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_we) begin
            valid_mem[clr_cnt_reg] <= '0;
            rank_mem[clr_cnt_reg]  <= rank_init;
        end else if (cmd.commit && access) begin
            valid_mem[set_reg] <= vld_wr;
            rank_mem[set_reg]  <= rank_wr;
            if (miss) tag_mem[set_reg] <= tag_wr;
        end
        if (cmd.accept) begin
            vld_rd_reg  <= valid_mem[rd_set];
            rank_rd_reg <= rank_mem[rd_set];
            tag_rd_reg  <= tag_mem[rd_set];
            set_reg     <= rd_set;
            tag_reg     <= in_tag;
            func_reg    <= in_func;
        end
    end

    // Totals and output register.
    logic [TOTAL_W-1:0]    hit_total_reg, miss_total_reg, evict_total_reg;
    logic [TOTAL_W-1:0]    hit_total_next, miss_total_next, evict_total_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_comb begin
        hit_total_next   = sat_add(hit_total_reg, hits_add);
        miss_total_next  = sat_add(miss_total_reg, {1'b0, miss});
        evict_total_next = sat_add(evict_total_reg, {1'b0, evict});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end else if (cmd.commit) begin
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            evict_total_reg <= evict_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= {4'b0000, evict_total_next, miss_total_next, hit_total_next,
                             evict, miss, hits_add};
        end
    end

    assign out_data = out_data_reg;

endmodule

/* design/set_assoc_lru_cache_tags_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_top
// Tag store of a set-associative cache with LRU replacement and saturating
// hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Flow: a new item is taken only once the previous one has committed; the
// accept cycle reads the set row from the set memories into registers, and the
// evaluation state then compares all ways and writes the row back at the commit.
// Output: the commit registers the result beat; evaluation waits while the
// output register is still full. Reset: clears controls, configuration and
// totals, then a clearing pass over all MAX_SETS sets resets the valid bits and
// LRU ranks; no beat is accepted during the pass, while configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_top import salc_pkg::*; #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [ADDR_W-1:0]      s_tdata,   // [63:0] address
    input  logic [FUNC_W-1:0]      s_tuser,   // [1:0] func
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] hits_added, [2] missed, [3] evicted, [35:4] hit_total,
    // [67:36] miss_total, [99:68] eviction_total, [103:100] zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    salc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    salc_datapath #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_func    (s_tuser),
        .in_address (s_tdata),
        .out_data   (m_tdata)
    );

endmodule

/* bench/tb_set_assoc_lru_cache_tags_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_tags_top
// Self-checking bench for the set-associative LRU cache tag store. A class
// keeps its own copy of the valid bits, tags, LRU ranks and saturating totals,
// predicts the outcome of every accepted access and compares each result beat
// field by field. The cache geometry is changed between phases, the extremes
// included, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_tags_top;
    import salc_pkg::*;

    localparam int MAX_SETS  = 64;
    localparam int MAX_WAYS  = 8;
    localparam int MAX_LINES = MAX_SETS * MAX_WAYS;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 65;
    localparam int LONG_HOLD_CYCLES = 120;

    // Access kinds that the package leaves unnamed.
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_STORE = 2'd1;
    // Register index past the end of the register list.
    localparam logic [1:0] CFG_SPARE  = 2'd3;

    typedef struct packed {
        logic [1:0]  hits_added;
        logic        missed;
        logic        evicted;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } access_outcome_t;

    class cache_scoreboard;
        logic [2:0]  set_bits;
        logic [5:0]  offset;
        logic [3:0]  ways;
        bit          line_ok   [MAX_LINES];
        logic [63:0] line_tag  [MAX_LINES];
        logic [2:0]  line_rank [MAX_LINES];
        logic [31:0] hit_total, miss_total, evict_total;
        access_outcome_t pending[$];
        int errors;
        int checked;

        function new();
            set_bits = 0;
            offset = 0;
            ways = 1;
            for (int i = 0; i < MAX_LINES; i++) begin
                line_ok[i] = 0;
                line_tag[i] = '0;
                line_rank[i] = 3'(i % MAX_WAYS);
            end
            hit_total = 0;
            miss_total = 0;
            evict_total = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [5:0] data);
            case (idx)
                CFG_SET_BITS: set_bits = data[2:0];
                CFG_OFFSET:   offset = data;
                CFG_WAYS:     ways = data[3:0];
                default: ;
            endcase
        endfunction

        // Set field width after clamping to the number of sets present.
        function int eff_set_bits();
            int s;
            s = set_bits;
            while (s > 0 && (1 << s) > MAX_SETS)
                s--;
            return s;
        endfunction

        function int eff_ways();
            if (ways < 1)
                return 1;
            if (ways > MAX_WAYS)
                return MAX_WAYS;
            return ways;
        endfunction

        function void promote(int base, int way);
            logic [2:0] r;
            r = line_rank[base + way];
            for (int k = 0; k < MAX_WAYS; k++)
                if (line_rank[base + k] > r)
                    line_rank[base + k]--;
            line_rank[base + way] = 3'(MAX_WAYS - 1);
        endfunction

        function bit lookup(logic [63:0] addr, output bit evicted);
            int s, nways, set_no, base, victim, best, shift;
            logic [63:0] tag;
            s = eff_set_bits();
            nways = eff_ways();
            set_no = int'((addr >> offset) & ((64'd1 << s) - 64'd1));
            shift = int'(offset) + s;
            tag = (shift >= 64) ? 64'd0 : (addr >> shift);
            base = set_no * MAX_WAYS;
            evicted = 0;
            for (int k = 0; k < nways; k++) begin
                if (line_ok[base + k] && line_tag[base + k] == tag) begin
                    promote(base, k);
                    return 1;
                end
            end
            // An empty way wins over any valid one; among equals the lowest rank.
            best = -1;
            victim = 0;
            for (int k = 0; k < nways; k++) begin
                if (!line_ok[base + k] && (best < 0 || line_rank[base + k] < best)) begin
                    best = line_rank[base + k];
                    victim = k;
                end
            end
            if (best < 0) begin
                for (int k = 0; k < nways; k++) begin
                    if (best < 0 || line_rank[base + k] < best) begin
                        best = line_rank[base + k];
                        victim = k;
                    end
                end
                evicted = 1;
            end
            line_ok[base + victim] = 1;
            line_tag[base + victim] = tag;
            promote(base, victim);
            return 0;
        endfunction

        function logic [31:0] sat_inc(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function void note_access(logic [1:0] func, logic [63:0] addr);
            access_outcome_t e;
            bit ev;
            e = '0;
            if (func != FUNC_NONE) begin
                if (lookup(addr, ev)) begin
                    e.hits_added = 1;
                    hit_total = sat_inc(hit_total);
                end else begin
                    e.missed = 1;
                    miss_total = sat_inc(miss_total);
                    if (ev) begin
                        e.evicted = 1;
                        evict_total = sat_inc(evict_total);
                    end
                end
                if (func == FUNC_MODIFY) begin
                    void'(lookup(addr, ev));
                    e.hits_added = e.hits_added + 2'd1;
                    hit_total = sat_inc(hit_total);
                end
            end
            e.hit_total = hit_total;
            e.miss_total = miss_total;
            e.evict_total = evict_total;
            pending.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (act !== exp) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            access_outcome_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result beat with no access outstanding, expected none, got %0h",
                         $time, d);
                return;
            end
            e = pending.pop_front();
            checked++;
            compare_field("hits_added", 32'(e.hits_added), 32'(d[1:0]));
            compare_field("missed", 32'(e.missed), 32'(d[2]));
            compare_field("evicted", 32'(e.evicted), 32'(d[3]));
            compare_field("hit_total", e.hit_total, d[35:4]);
            compare_field("miss_total", e.miss_total, d[67:36]);
            compare_field("eviction_total", e.evict_total, d[99:68]);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ADDR_W-1:0]      s_tdata;   // [63:0] address
    logic [FUNC_W-1:0]      s_tuser;   // [1:0] func
    logic                   m_tvalid;
    logic                   m_tready;
    // [1:0] hits_added, [2] missed, [3] evicted, [35:4] hit_total,
    // [67:36] miss_total, [99:68] eviction_total, [103:100] zero
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cache_scoreboard sb;
    logic [63:0] recent_addrs[$];
    bit sender_gaps_on;
    bit receiver_stalls_on;
    bit hold_output;
    int accesses_sent;

    set_assoc_lru_cache_tags_top #(
        .MAX_SETS(MAX_SETS),
        .MAX_WAYS(MAX_WAYS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [5:0] sbits, input logic [5:0] obits,
                                input logic [5:0] nways);
        write_reg(CFG_SET_BITS, sbits);
        write_reg(CFG_OFFSET, obits);
        write_reg(CFG_WAYS, nways);
    endtask

    // Valid stays high from one beat into the next when there is no gap.
    task automatic send_access(input logic [1:0] func, input logic [63:0] addr);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 14) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        s_tuser <= func;
        do @(posedge aclk); while (!s_tready);
        sb.note_access(func, addr);
        accesses_sent++;
    endtask

    // Lets every outstanding result arrive, then idles quietly before returning.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() > 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Mostly addresses that land in a few sets with a few tags, so that sets
    // fill up and lines get reused and evicted; the rest is fully random.
    function automatic logic [63:0] pick_address();
        int r, s, shift;
        logic [63:0] a, set_no, tag;
        r = $urandom_range(0, 9);
        a = {$urandom, $urandom};
        if (r < 2)
            return a;
        if (r < 5 && recent_addrs.size() > 0)
            return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        s = sb.eff_set_bits();
        shift = int'(sb.offset) + s;
        set_no = 64'($urandom_range(0, 3)) & ((64'd1 << s) - 64'd1);
        tag = 64'($urandom_range(0, sb.eff_ways() + 2));
        if ($urandom_range(0, 7) == 0)
            tag = tag | {$urandom, 32'd0};
        a = a & ((64'd1 << sb.offset) - 64'd1);
        a = a | (set_no << sb.offset);
        if (shift < 64)
            a = a | (tag << shift);
        recent_addrs.push_back(a);
        if (recent_addrs.size() > 16)
            void'(recent_addrs.pop_front());
        return a;
    endfunction

    function automatic logic [1:0] pick_func();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return FUNC_NONE;
        if (r < 8)
            return FUNC_LOAD;
        if (r < 14)
            return FUNC_STORE;
        return FUNC_MODIFY;
    endfunction

    // Result side: one draw of stall cycles per beat.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = receiver_stalls_on ? $urandom_range(0, 14) : 0;
            @(negedge aclk);
            if (hold_output) begin
                hold_output = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        int geo [NUM_PHASES][3];
        geo = '{
            '{2, 4, 4}, '{6, 0, 8}, '{63, 63, 63}, '{6, 58, 8}, '{0, 0, 0},
            '{3, 6, 9}, '{1, 32, 3}, '{4, 12, 2}, '{5, 20, 7}, '{0, 60, 8}
        };
        sb = new();
        accesses_sent = 0;
        sender_gaps_on = 1'b1;
        receiver_stalls_on = 1'b1;
        hold_output = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_LOAD;
        cfg_valid = 1'b0;
        cfg_index = CFG_SET_BITS;
        cfg_data = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: a single set with one way.
        send_access(FUNC_LOAD, 64'd0);
        send_access(FUNC_LOAD, 64'd0);
        send_access(FUNC_STORE, '1);
        send_access(FUNC_MODIFY, '1);
        send_access(FUNC_MODIFY, 64'd0);
        send_access(FUNC_NONE, 64'h5555_5555_5555_5555);
        send_access(FUNC_LOAD, 64'h8000_0000_0000_0000);
        drain();

        // A write past the register list must leave the geometry alone.
        write_reg(CFG_SPARE, 6'd63);
        set_geometry(6'd2, 6'd4, 6'd4);
        for (int t = 1; t <= 4; t++)
            send_access(FUNC_LOAD, 64'(t) << 6);
        send_access(FUNC_LOAD, 64'd1 << 6);
        send_access(FUNC_LOAD, 64'd5 << 6);
        send_access(FUNC_LOAD, 64'd2 << 6);
        send_access(FUNC_STORE, 64'd1 << 6);
        drain();

        // Growing the way count leaves empty ways that must be filled first.
        write_reg(CFG_WAYS, 6'd8);
        send_access(FUNC_LOAD, 64'd9 << 6);
        drain();

        // Largest register values: set field clamps, the tag collapses to zero.
        set_geometry(6'd63, 6'd63, 6'd63);
        send_access(FUNC_LOAD, '1);
        send_access(FUNC_MODIFY, 64'd0);
        drain();
        write_reg(CFG_WAYS, 6'd0);
        send_access(FUNC_STORE, 64'h7FFF_FFFF_FFFF_FFFF);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_geometry(6'(geo[p][0]), 6'(geo[p][1]), 6'(geo[p][2]));
            if (p == 5)
                write_reg(CFG_SPARE, 6'($urandom_range(0, 63)));
            recent_addrs.delete();
            sender_gaps_on = (p % 3 != 0);
            receiver_stalls_on = (p % 4 != 1);
            // Back up the result side while the input side keeps pushing.
            if (p == 2) begin
                sender_gaps_on = 1'b0;
                hold_output = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_access(pick_func(), pick_address());
            drain();
        end

        if (sb.pending.size() > 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending.size());
        end
        $display("Ran %0d accesses over %0d cache geometries, %0d results checked.",
                 accesses_sent, NUM_PHASES + 4, sb.checked);
        $display("Totals seen: %0d hits, %0d misses, %0d evictions.",
                 sb.hit_total, sb.miss_total, sb.evict_total);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
